FILE: design/dts_pkg.sv
// Package: types, constants and codes of the deadline timer scheduler.
`default_nettype none
package dts_pkg;
    localparam int unsigned TimerSlotsDefault = 16;
    localparam int unsigned MaxFires          = 16;
    localparam int unsigned TimeW             = 63;
    localparam int unsigned PeriodW           = 47;
    localparam int unsigned DelayW            = 48;
    localparam int unsigned CountW            = 32;
    localparam logic [TimeW-1:0] ResetClock   = 63'd9876543210;
    localparam logic [TimeW-1:0] TopTime      = {TimeW{1'b1}};

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_RESCHED = 2'd2,
        FUNC_CANCEL = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        KIND_FIRED     = 3'd0,
        KIND_INSERTED  = 3'd1,
        KIND_RESCHED   = 3'd2,
        KIND_CANCELLED = 3'd3,
        KIND_NOT_FOUND = 3'd4,
        KIND_FULL      = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_FIRE,
        ST_CMD,
        ST_OUT
    } state_t;

    // Add a signed delay to a base time, clamped to 0..TopTime.
    function automatic logic [TimeW-1:0] shifted_time(
        input logic [TimeW-1:0]  base,
        input logic [DelayW-1:0] delay
    );
        logic [TimeW:0] sum;
        logic [TimeW:0] mag;
        begin
            sum = '0;
            mag = '0;
            if (delay[DelayW-1]) begin
                mag = {{(TimeW+1-DelayW){1'b0}}, (~delay + 1'b1)};
                shifted_time = (mag > {1'b0, base}) ? '0 : base - mag[TimeW-1:0];
            end else begin
                sum = {1'b0, base} + {{(TimeW+1-DelayW){1'b0}}, delay};
                shifted_time = sum[TimeW] ? TopTime : sum[TimeW-1:0];
            end
        end
    endfunction
endpackage
`default_nettype wire

FILE: design/deadline_timer_scheduler_core.sv
// Top level: timer table in one memory, scanned per tick by a sequencer.
//
//  channel | dir | fields (tdata low bit up)                      | side
//  s_axis  | in  | func, timer_id, first_delay, period (101 -> 104b)| slave
//  m_axis  | out | kind, slot, fire_time, fire_count (102 -> 104b); last on tlast
//
// Insert, reschedule and cancel pass through accept, table update and result.
// A tick with k fires runs k+1 searches: each search is a read sweep of all
// TIMER_SLOTS entries on the single memory read port, plus a pick state and a
// read-modify-write per fire, plus accept and close.
// Valid and done bits sit in flip-flops cleared by reset; payload needs none.
// One result register decouples m_axis stalls; the sequencer waits on it, and a
// fire stays hidden there until the next sweep settles its last flag.
`default_nettype none
module deadline_timer_scheduler_core #(
    parameter int unsigned TIMER_SLOTS = dts_pkg::TimerSlotsDefault
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // func[1:0], timer_id[5:2], first_delay[53:6], period[100:54], zero pad
    input  wire logic [103:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // kind[2:0], slot[6:3], fire_time[69:7], fire_count[101:70], zero pad
    output logic [103:0]      m_axis_tdata,
    output logic              m_axis_tlast
);
    localparam int unsigned IdxW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int unsigned CntW = $clog2(TIMER_SLOTS + 1);
    localparam int unsigned FireW = $clog2(dts_pkg::MaxFires + 1);

    typedef struct packed {
        logic [dts_pkg::TimeW-1:0]   deadline;
        logic [dts_pkg::PeriodW-1:0] period;
        logic [dts_pkg::CountW-1:0]  count;
    } entry_t;

    // Timer memory: one write port, one registered read port.
    entry_t mem [TIMER_SLOTS];
    logic            mem_we;
    logic [IdxW-1:0] mem_waddr;
    entry_t          mem_wdata;
    logic [IdxW-1:0] mem_raddr;
    entry_t          mem_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        mem_rdata_reg <= mem[mem_raddr];
    end

    dts_pkg::state_t state_reg, state_next;
    logic [dts_pkg::TimeW-1:0] clock_reg, clock_next;
    logic [TIMER_SLOTS-1:0] valid_reg, valid_next;
    logic [TIMER_SLOTS-1:0] done_reg, done_next;
    logic [CntW-1:0] scan_reg, scan_next;
    logic            rd_pend_reg, rd_pend_next;
    logic [IdxW-1:0] rd_idx_reg, rd_idx_next;
    logic            best_ok_reg, best_ok_next;
    logic [IdxW-1:0] best_reg, best_next;
    logic [dts_pkg::TimeW-1:0] best_dl_reg, best_dl_next;
    logic [FireW-1:0] fires_reg, fires_next;
    dts_pkg::func_t  func_reg, func_next;
    logic [3:0]      id_reg, id_next;
    logic [dts_pkg::DelayW-1:0]  delay_reg, delay_next;
    logic [dts_pkg::PeriodW-1:0] per_reg, per_next;
    logic            ov_reg, ov_next;
    logic [103:0]    od_reg, od_next;
    logic            ol_reg, ol_next;
    logic            hv_reg;
    logic [dts_pkg::TimeW-1:0] new_dl;
    logic [dts_pkg::TimeW:0]   rearm_sum;
    logic [dts_pkg::CountW-1:0] new_cnt;
    logic [IdxW-1:0] free_idx;
    logic            free_ok;
    logic [IdxW-1:0] id_idx;
    logic            id_ok;
    logic            out_xfer;
    logic            out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= dts_pkg::ST_IDLE;
            clock_reg   <= dts_pkg::ResetClock;
            valid_reg   <= '0;
            done_reg    <= '0;
            rd_pend_reg <= 1'b0;
            best_ok_reg <= 1'b0;
            fires_reg   <= '0;
            ov_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clock_reg   <= clock_next;
            valid_reg   <= valid_next;
            done_reg    <= done_next;
            rd_pend_reg <= rd_pend_next;
            best_ok_reg <= best_ok_next;
            fires_reg   <= fires_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        rd_idx_reg  <= rd_idx_next;
        best_reg    <= best_next;
        best_dl_reg <= best_dl_next;
        func_reg    <= func_next;
        id_reg      <= id_next;
        delay_reg   <= delay_next;
        per_reg     <= per_next;
        od_reg      <= od_next;
        ol_reg      <= ol_next;
    end

    // Lowest free slot.
    always_comb
    begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_ok  = 1'b1;
                free_idx = IdxW'(i);
            end
        end
    end

    assign id_idx   = IdxW'(id_reg);
    assign id_ok    = ({28'd0, id_reg} < TIMER_SLOTS) && valid_reg[id_idx];
    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign out_free = !ov_reg || out_xfer;
    assign new_dl   = dts_pkg::shifted_time(clock_reg, delay_reg);
    assign rearm_sum = {1'b0, mem_rdata_reg.deadline}
                     + {{(dts_pkg::TimeW+1-dts_pkg::PeriodW){1'b0}}, mem_rdata_reg.period};
    assign new_cnt  = mem_rdata_reg.count + 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dts_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = (dts_pkg::func_t'(s_axis_tdata[1:0]) == dts_pkg::FUNC_TICK)
                               ? dts_pkg::ST_SCAN : dts_pkg::ST_CMD;
            end
            dts_pkg::ST_SCAN:
            begin
                if (scan_reg == CntW'(TIMER_SLOTS) && !rd_pend_reg)
                    state_next = dts_pkg::ST_PICK;
            end
            dts_pkg::ST_PICK:
            begin
                if (!best_ok_reg || fires_reg == FireW'(dts_pkg::MaxFires))
                    state_next = dts_pkg::ST_OUT;
                else
                    state_next = dts_pkg::ST_FIRE;
            end
            dts_pkg::ST_FIRE:
            begin
                if (out_free && !rd_pend_reg)
                    state_next = dts_pkg::ST_SCAN;
            end
            dts_pkg::ST_CMD:
            begin
                if (out_free)
                    state_next = dts_pkg::ST_OUT;
            end
            dts_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = dts_pkg::ST_IDLE;
            end
            default: state_next = dts_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        clock_next   = clock_reg;
        valid_next   = valid_reg;
        done_next    = done_reg;
        scan_next    = scan_reg;
        rd_pend_next = 1'b0;
        rd_idx_next  = rd_idx_reg;
        best_ok_next = best_ok_reg;
        best_next    = best_reg;
        best_dl_next = best_dl_reg;
        fires_next   = fires_reg;
        func_next    = func_reg;
        id_next      = id_reg;
        delay_next   = delay_reg;
        per_next     = per_reg;
        ov_next      = ov_reg && !out_xfer;
        od_next      = od_reg;
        ol_next      = ol_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = scan_reg[IdxW-1:0];
        s_axis_tready = 1'b0;
        case (state_reg)
            dts_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                func_next  = dts_pkg::func_t'(s_axis_tdata[1:0]);
                id_next    = s_axis_tdata[5:2];
                delay_next = s_axis_tdata[53:6];
                per_next   = s_axis_tdata[100:54];
                done_next  = '0;
                fires_next = '0;
                scan_next  = '0;
                best_ok_next = 1'b0;
                if (s_axis_tvalid && dts_pkg::func_t'(s_axis_tdata[1:0]) == dts_pkg::FUNC_TICK
                    && clock_reg != dts_pkg::TopTime)
                    clock_next = clock_reg + 1'b1;
            end
            dts_pkg::ST_SCAN:
            begin
                // Issue one read a cycle, compare the returned entry.
                if (scan_reg != CntW'(TIMER_SLOTS)) begin
                    rd_pend_next = 1'b1;
                    rd_idx_next  = scan_reg[IdxW-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                if (rd_pend_reg && valid_reg[rd_idx_reg] && !done_reg[rd_idx_reg]
                    && mem_rdata_reg.deadline <= clock_reg
                    && (!best_ok_reg || mem_rdata_reg.deadline < best_dl_reg)) begin
                    best_ok_next = 1'b1;
                    best_next    = rd_idx_reg;
                    best_dl_next = mem_rdata_reg.deadline;
                end
            end
            dts_pkg::ST_PICK:
            begin
                // Read the winner back for the update.
                mem_raddr    = best_reg;
                rd_pend_next = 1'b1;
                if (!best_ok_reg || fires_reg == FireW'(dts_pkg::MaxFires))
                    ol_next = 1'b1;
            end
            dts_pkg::ST_FIRE:
            begin
                // Keep the winner on the read port while the output drains.
                mem_raddr = best_reg;
                if (out_free && !rd_pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = best_reg;
                    mem_wdata.count  = new_cnt;
                    mem_wdata.period = mem_rdata_reg.period;
                    mem_wdata.deadline = rearm_sum[dts_pkg::TimeW] ? dts_pkg::TopTime
                                                                   : rearm_sum[dts_pkg::TimeW-1:0];
                    if (mem_rdata_reg.period == '0) begin
                        valid_next[best_reg] = 1'b0;
                        mem_wdata.deadline   = mem_rdata_reg.deadline;
                    end
                    done_next[best_reg] = 1'b1;
                    fires_next   = fires_reg + 1'b1;
                    ov_next      = 1'b1;
                    od_next      = {2'b00, new_cnt, clock_reg, 4'(best_reg), dts_pkg::KIND_FIRED};
                    ol_next      = 1'b0;
                    scan_next    = '0;
                    best_ok_next = 1'b0;
                end
            end
            dts_pkg::ST_CMD:
            begin
                if (out_free) begin
                    ov_next = 1'b1;
                    ol_next = 1'b1;
                    if (func_reg == dts_pkg::FUNC_INSERT) begin
                        if (free_ok) begin
                            valid_next[free_idx] = 1'b1;
                            mem_we    = 1'b1;
                            mem_waddr = free_idx;
                            mem_wdata = '{deadline: new_dl, period: per_reg, count: '0};
                            od_next   = {97'd0, 4'(free_idx), dts_pkg::KIND_INSERTED};
                        end else begin
                            od_next = {101'd0, dts_pkg::KIND_FULL};
                        end
                    end else if (!id_ok) begin
                        od_next = {97'd0, id_reg, dts_pkg::KIND_NOT_FOUND};
                    end else if (func_reg == dts_pkg::FUNC_RESCHED) begin
                        // Keep the count: instead of a separate read before the write,
                        // the count field comes from a read issued in ST_IDLE.
                        mem_we    = 1'b1;
                        mem_waddr = id_idx;
                        mem_wdata = '{deadline: new_dl, period: per_reg,
                                      count: mem_rdata_reg.count};
                        od_next   = {97'd0, id_reg, dts_pkg::KIND_RESCHED};
                    end else begin
                        valid_next[id_idx] = 1'b0;
                        od_next = {97'd0, id_reg, dts_pkg::KIND_CANCELLED};
                    end
                end
                mem_raddr = id_idx;
            end
            dts_pkg::ST_OUT:
            begin
                // Wait for the final result of the item to leave.
                ov_next = ov_reg && !out_xfer;
            end
            default: ;
        endcase
        if (state_reg == dts_pkg::ST_IDLE)
            mem_raddr = IdxW'(s_axis_tdata[5:2]);
    end

    // Hold a fire back until the next sweep tells whether it is the last.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hv_reg <= 1'b0;
        else if (state_reg == dts_pkg::ST_FIRE && out_free && !rd_pend_reg)
            hv_reg <= 1'b1;
        else if (state_reg == dts_pkg::ST_PICK)
            hv_reg <= 1'b0;
    end

    assign m_axis_tvalid = ov_reg && !hv_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tlast  = ol_reg;

    // Sequencer only accepts in idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == dts_pkg::ST_IDLE)
        else $error("input accepted outside idle");
    // Never overwrite a pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result lost");
    // Fires per tick are bounded.
    assert property (@(posedge clk) disable iff (!rst_n)
        fires_reg <= FireW'(dts_pkg::MaxFires))
        else $error("too many fires");
    // A fired slot is marked done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dts_pkg::ST_FIRE && out_free && !rd_pend_reg) |=> done_reg[$past(best_reg)])
        else $error("fired slot not marked");
endmodule
`default_nettype wire
